@@ rtl/core/acre_pkg.sv @@
package acre_pkg;

	localparam int     BASE_W     = 8;
	localparam int     CNT_W      = 17;
	localparam int     OP_W       = 2;
	localparam int     NUM_REC    = 3;
	localparam longint MAX_COLUMNS = 64'd65536;
	localparam longint FIELD_MAX   = 64'd131071;

	localparam logic [CNT_W-1:0] COUNT_CAP =
		CNT_W'((MAX_COLUMNS < FIELD_MAX) ? MAX_COLUMNS : FIELD_MAX);

	localparam logic [BASE_W-1:0] GAP_BYTE = 8'd45;

	// column class; NONE marks no open run, SKIP a double gap
	typedef logic [2:0] cls_t;
	localparam cls_t CLS_MATCH    = 3'd0;
	localparam cls_t CLS_MISMATCH = 3'd1;
	localparam cls_t CLS_INSERT   = 3'd2;
	localparam cls_t CLS_DELETE   = 3'd3;
	localparam cls_t CLS_NONE     = 3'd4;
	localparam cls_t CLS_SKIP     = 3'd5;

	localparam logic KIND_RUN     = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		cls_t             open_op;
		logic [CNT_W-1:0] open_len;
		logic [CNT_W-1:0] aligned;
		logic [CNT_W-1:0] events;
	} state_t;

	typedef struct packed {
		logic             kind;
		logic [OP_W-1:0]  op;
		logic [CNT_W-1:0] len;
		logic [CNT_W-1:0] aligned;
		logic [CNT_W-1:0] events;
		logic             last;
	} record_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v < COUNT_CAP) ? v + CNT_W'(1) : COUNT_CAP;
	endfunction

endpackage

@@ rtl/core/acre_step.sv @@
module acre_step (
	input  logic                          cs_mode,
	input  logic [acre_pkg::BASE_W-1:0]   target_base,
	input  logic [acre_pkg::BASE_W-1:0]   query_base,
	input  logic                          last_column,
	input  acre_pkg::state_t              st_cur,
	output acre_pkg::state_t              st_nxt,
	output acre_pkg::record_t [acre_pkg::NUM_REC-1:0] recs,
	output logic [1:0]                    rec_n
);
	import acre_pkg::*;

	always_comb begin
		logic   tgap;
		logic   qgap;
		cls_t   op;
		state_t s;
		logic [1:0] n;
		record_t r;

		tgap = (target_base == GAP_BYTE);
		qgap = (query_base == GAP_BYTE);
		s    = st_cur;
		n    = 2'd0;
		recs = '0;
		r    = '0;

		priority if (!tgap && !qgap) begin
			op = (cs_mode && (target_base != query_base)) ? CLS_MISMATCH : CLS_MATCH;
			s.aligned = sat_inc(s.aligned);
		end else if (tgap && !qgap) begin
			op = CLS_INSERT;
		end else if (!tgap && qgap) begin
			op = CLS_DELETE;
		end else begin
			op = CLS_SKIP;
		end

		if (op != CLS_SKIP) begin
			// mismatches never merge
			if ((op != s.open_op) || (op == CLS_MISMATCH)) begin
				if (s.open_op != CLS_NONE) begin
					r      = '0;
					r.kind = KIND_RUN;
					r.op   = s.open_op[OP_W-1:0];
					r.len  = s.open_len;
					recs[n] = r;
					n = n + 2'd1;
				end
				s.open_op  = op;
				s.open_len = '0;
			end
			s.open_len = sat_inc(s.open_len);
			s.events   = sat_inc(s.events);
		end

		if (last_column) begin
			if (s.open_op != CLS_NONE) begin
				r      = '0;
				r.kind = KIND_RUN;
				r.op   = s.open_op[OP_W-1:0];
				r.len  = s.open_len;
				recs[n] = r;
				n = n + 2'd1;
			end
			r         = '0;
			r.kind    = KIND_SUMMARY;
			r.aligned = s.aligned;
			r.events  = s.events;
			recs[n]   = r;
			n = n + 2'd1;
			s.open_op  = CLS_NONE;
			s.open_len = '0;
			s.aligned  = '0;
			s.events   = '0;
		end

		if (n != 2'd0) begin
			recs[n - 2'd1].last = 1'b1;
		end

		st_nxt = s;
		rec_n  = n;
	end

endmodule

@@ rtl/core/alignment_cigar_run_encoder.sv @@
// channel  | dir | signals                          | content
// ---------+-----+----------------------------------+------------------------------------
// s_*      | in  | s_tvalid s_tready s_tdata s_tlast | one alignment column, tlast ends block
// m_*      | out | m_tvalid m_tready m_tdata m_tuser | run or summary record, tlast = final
//          |     | m_tlast                           | record of its column
// cfg_*    | in  | cfg_valid cfg_ready cfg_data      | cs_mode
//
// A column is held in the input register, then is classified and its
// records (0 to 3) are loaded into a three-entry record buffer in one step.
// One column per cycle while each yields at most one record and m_tready is
// high; a column with several records holds the single output port for each in turn, which sets the rate.
// Reset clears the run state, counters, buffer count and cs_mode. Either side
// may stall at any time; a stalled output holds the input register once full.
module alignment_cigar_run_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] target_base, [15:8] query_base
	input  logic        s_tlast,   // last_column
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [1:0] run_op, [18:2] run_length,
	                               // [35:19] aligned_count, [52:36] event_count
	output logic [0:0]  m_tuser,   // [0] record_kind
	output logic        m_tlast,   // last_record
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // cs_mode
);
	import acre_pkg::*;

	logic                cs_mode_q;
	logic                v_s1;
	logic [BASE_W-1:0]   tgt_s1;
	logic [BASE_W-1:0]   qry_s1;
	logic                last_s1;
	state_t              st_q;
	state_t              st_nxt;
	record_t [NUM_REC-1:0] step_recs;
	logic [1:0]          step_n;
	record_t             rec_q [NUM_REC];
	logic [1:0]          cnt_q;
	logic                take;
	logic                go;

	acre_step u_step (
		.cs_mode     (cs_mode_q),
		.target_base (tgt_s1),
		.query_base  (qry_s1),
		.last_column (last_s1),
		.st_cur      (st_q),
		.st_nxt      (st_nxt),
		.recs        (step_recs),
		.rec_n       (step_n)
	);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = (cnt_q != 2'd0);
	assign take      = m_tvalid && m_tready;
	// buffer must be drained by the end of this cycle before new records load
	assign go        = v_s1 && ((step_n == 2'd0) || (cnt_q == 2'd0) ||
	                            ((cnt_q == 2'd1) && m_tready));
	assign s_tready  = !v_s1 || go;

	assign m_tdata   = {3'b000, rec_q[0].events, rec_q[0].aligned, rec_q[0].len, rec_q[0].op};
	assign m_tuser   = rec_q[0].kind;
	assign m_tlast   = rec_q[0].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			cs_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tgt_s1  <= s_tdata[7:0];
			qry_s1  <= s_tdata[15:8];
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.open_op  <= CLS_NONE;
			st_q.open_len <= '0;
			st_q.aligned  <= '0;
			st_q.events   <= '0;
		end else if (go) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (go && (step_n != 2'd0)) begin
			cnt_q <= step_n;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go && (step_n != 2'd0)) begin
			rec_q[0] <= step_recs[0];
			rec_q[1] <= step_recs[1];
			rec_q[2] <= step_recs[2];
		end else if (take) begin
			rec_q[0] <= rec_q[1];
			rec_q[1] <= rec_q[2];
		end
	end

`ifndef NO_ASSERTIONS
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (step_n != 2'd0)) |=> (cnt_q == $past(step_n)))
		else $error("record buffer count differs from records loaded");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("summary record not flagged as final");

	a_block_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(go && last_s1) |=> ((st_q.open_op == CLS_NONE) && (st_q.events == '0)))
		else $error("state not cleared after end of block");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[18:2] != '0))
		else $error("run record with zero length");
`endif

endmodule

@@ test/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import acre_pkg::*;

	typedef struct {
		logic [7:0] target;
		logic [7:0] query;
		bit         last;
		bit         mode;
		bit         lit;
		record_t    want;
	} col_row_t;

	localparam record_t NO_REC = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	// predictor copy of the encoder state
	bit               cs_mode_q = 1'b0;
	cls_t             open_cls = CLS_NONE;
	logic [CNT_W-1:0] open_len = '0;
	logic [CNT_W-1:0] aligned_tot = '0;
	logic [CNT_W-1:0] event_tot = '0;
	record_t          pending_q[$];

	int errors = 0;
	int columns_sent = 0;
	int src_idle = 11;
	int snk_idle = 71;

	col_row_t plan [20] = '{
		'{"A", "A", 1'b1, 1'b0, 1'b1, '{KIND_SUMMARY, 2'd0, 17'd0, 17'd1, 17'd1, 1'b1}},
		'{GAP_BYTE, GAP_BYTE, 1'b1, 1'b0, 1'b1,
			'{KIND_SUMMARY, 2'd0, 17'd0, 17'd0, 17'd0, 1'b1}},
		'{8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
		'{8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, NO_REC},
		'{GAP_BYTE, "C", 1'b0, 1'b0, 1'b0, NO_REC},
		'{GAP_BYTE, "G", 1'b0, 1'b0, 1'b0, NO_REC},
		'{"T", GAP_BYTE, 1'b0, 1'b0, 1'b0, NO_REC},
		'{GAP_BYTE, GAP_BYTE, 1'b0, 1'b0, 1'b0, NO_REC},
		'{"G", GAP_BYTE, 1'b0, 1'b0, 1'b0, NO_REC},
		'{8'd44, 8'd46, 1'b0, 1'b0, 1'b0, NO_REC},
		// mode flips inside the open block
		'{"A", "C", 1'b0, 1'b1, 1'b0, NO_REC},
		'{"C", "A", 1'b0, 1'b1, 1'b0, NO_REC},
		'{"G", "G", 1'b0, 1'b1, 1'b0, NO_REC},
		'{"G", "T", 1'b1, 1'b1, 1'b0, NO_REC},
		'{8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, '{KIND_SUMMARY, 2'd0, 17'd0, 17'd1, 17'd1, 1'b1}},
		'{8'h00, GAP_BYTE, 1'b1, 1'b1, 1'b1,
			'{KIND_SUMMARY, 2'd0, 17'd0, 17'd0, 17'd1, 1'b1}},
		'{GAP_BYTE, 8'h00, 1'b0, 1'b1, 1'b0, NO_REC},
		'{GAP_BYTE, GAP_BYTE, 1'b1, 1'b1, 1'b1,
			'{KIND_SUMMARY, 2'd0, 17'd0, 17'd0, 17'd1, 1'b1}},
		'{8'hAA, 8'h55, 1'b0, 1'b0, 1'b0, NO_REC},
		'{8'h55, 8'hAA, 1'b1, 1'b0, 1'b0, NO_REC}
	};

	alignment_cigar_run_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == COUNT_CAP) ? v : v + 1'b1;
	endfunction

	function logic [7:0] base_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		return (b == GAP_BYTE) ? ~b : b;
	endfunction

	// expected run and summary records for one accepted column
	function void predict_column(input logic [7:0] t, input logic [7:0] q, input bit last);
		cls_t    c;
		record_t rec [3];
		int      n;
		n = 0;
		if (t != GAP_BYTE && q != GAP_BYTE) begin
			c = (cs_mode_q && t != q) ? CLS_MISMATCH : CLS_MATCH;
			aligned_tot = bump(aligned_tot);
		end else if (t == GAP_BYTE && q != GAP_BYTE) begin
			c = CLS_INSERT;
		end else if (t != GAP_BYTE) begin
			c = CLS_DELETE;
		end else begin
			c = CLS_SKIP;
		end
		if (c != CLS_SKIP) begin
			// a mismatch never extends an open mismatch run
			if (c != open_cls || c == CLS_MISMATCH) begin
				if (open_cls != CLS_NONE) begin
					rec[n] = '{KIND_RUN, open_cls[1:0], open_len, '0, '0, 1'b0};
					n++;
				end
				open_cls = c;
				open_len = '0;
			end
			open_len = bump(open_len);
			event_tot = bump(event_tot);
		end
		if (last) begin
			if (open_cls != CLS_NONE) begin
				rec[n] = '{KIND_RUN, open_cls[1:0], open_len, '0, '0, 1'b0};
				n++;
			end
			rec[n] = '{KIND_SUMMARY, 2'd0, '0, aligned_tot, event_tot, 1'b0};
			n++;
			open_cls = CLS_NONE;
			open_len = '0;
			aligned_tot = '0;
			event_tot = '0;
		end
		for (int i = 0; i < n; i++) begin
			rec[i].last = (i == n - 1);
			pending_q.push_back(rec[i]);
		end
	endfunction

	task flag_error(input string msg);
		$display("%0t ns: %s", $realtime, msg);
		errors++;
	endtask

	task check_field(input string name, input int got, input int want);
		if (got != want)
			flag_error($sformatf("%s: got %0d, expected %0d", name, got, want));
	endtask

	task send_column(input logic [7:0] t, input logic [7:0] q, input bit last);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {q, t};
		s_tlast <= last;
		// hold the request until the encoder takes it
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_column(t, q, last);
		columns_sent++;
	endtask

	// skip columns leave no record behind, so allow the pipe to settle too
	task wait_drained();
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_mode(input bit v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cs_mode_q = v;
	endtask

	task send_random_block();
		int         len;
		int         r;
		cls_t       pick;
		logic [7:0] t;
		logic [7:0] q;
		len = $urandom_range(12, 1);
		pick = CLS_MATCH;
		for (int i = 0; i < len; i++) begin
			// keep the previous class often so that runs grow
			if ($urandom_range(99) < 45) begin
				r = $urandom_range(99);
				pick = (r < 40) ? CLS_MATCH : (r < 55) ? CLS_INSERT :
					(r < 70) ? CLS_DELETE : (r < 82) ? CLS_SKIP : CLS_NONE;
			end
			case (pick)
				CLS_MATCH: begin
					t = base_byte();
					q = $urandom_range(1) ? t : base_byte();
				end
				CLS_INSERT: begin
					t = GAP_BYTE;
					q = base_byte();
				end
				CLS_DELETE: begin
					t = base_byte();
					q = GAP_BYTE;
				end
				CLS_SKIP: begin
					t = GAP_BYTE;
					q = GAP_BYTE;
				end
				default: begin
					t = 8'($urandom_range(255));
					q = 8'($urandom_range(255));
				end
			endcase
			if ($urandom_range(49) == 0)
				wait_drained();
			send_column(t, q, i == len - 1);
		end
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		record_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				flag_error($sformatf("unexpected record: kind %0d op %0d len %0d",
					m_tuser[0], m_tdata[1:0], m_tdata[18:2]));
			end else begin
				want = pending_q.pop_front();
				check_field("record_kind", m_tuser[0], want.kind);
				check_field("run_op", m_tdata[1:0], want.op);
				check_field("run_length", m_tdata[18:2], want.len);
				check_field("aligned_count", m_tdata[35:19], want.aligned);
				check_field("event_count", m_tdata[52:36], want.events);
				check_field("last_record", m_tlast, want.last);
			end
		end
	end

	initial begin
		int base;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].mode != cs_mode_q)
				write_mode(plan[i].mode);
			send_column(plan[i].target, plan[i].query, plan[i].last);
			if (plan[i].lit)
				pending_q[$] = plan[i].want;
		end

		for (int ph = 0; ph < 3; ph++) begin
			src_idle = (ph == 0) ? 11 : (ph == 1) ? 71 : 0;
			snk_idle = (ph == 0) ? 71 : (ph == 1) ? 11 : 0;
			write_mode((ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(1)));
			base = columns_sent;
			while (columns_sent - base < 28)
				send_random_block();
		end

		s_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
